FILE: rtl/ctt_pkg.sv
`timescale 1ns / 1ps

package ctt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SPACE  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_NUMBER = 3'd3,
    MODE_IDENT  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    KIND_DOT    = 4'd0,
    KIND_EQ     = 4'd1,
    KIND_SEMI   = 4'd2,
    KIND_OPEN   = 4'd3,
    KIND_CLOSE  = 4'd4,
    KIND_NL     = 4'd5,
    KIND_SPACE  = 4'd6,
    KIND_STRING = 4'd7,
    KIND_NUMBER = 4'd8,
    KIND_IDENT  = 4'd9,
    KIND_OTHER  = 4'd10,
    KIND_END    = 4'd11
  } kind_t;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       char_valid;
    logic       token_last;
  } result_t;

  // All results caused by one request, in emission order from index 0.
  typedef struct packed {
    logic [1:0]                    cnt;
    result_t [MAX_RESULTS-1:0]     res;
  } bundle_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_char;
    logic       held_valid;
    logic       quote_single;
    logic       escape;
  } lex_regs_t;

  typedef struct packed {
    lex_regs_t r;
    bundle_t   b;
  } lex_work_t;

endpackage

FILE: rtl/ctt_front.sv
`timescale 1ns / 1ps

module ctt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                q_full,
  output logic                push,
  output ctt_pkg::bundle_t    push_data
);

  ctt_pkg::lex_regs_t regs;
  ctt_pkg::lex_work_t work;
  logic               accept;

  function automatic ctt_pkg::kind_t mode_kind(ctt_pkg::mode_t m);
    case (m)
      ctt_pkg::MODE_SPACE:  return ctt_pkg::KIND_SPACE;
      ctt_pkg::MODE_STRING: return ctt_pkg::KIND_STRING;
      ctt_pkg::MODE_NUMBER: return ctt_pkg::KIND_NUMBER;
      default:              return ctt_pkg::KIND_IDENT;
    endcase
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ctt_pkg::CH_SPACE) ||
           ((c >= ctt_pkg::CH_TAB) && (c <= ctt_pkg::CH_CR) && (c != ctt_pkg::CH_NL));
  endfunction

  function automatic logic continues(ctt_pkg::mode_t m, logic [7:0] c);
    case (m)
      ctt_pkg::MODE_SPACE:  return is_blank(c);
      ctt_pkg::MODE_NUMBER: return is_digit(c) || is_alpha(c) || (c == ctt_pkg::CH_DOT);
      ctt_pkg::MODE_IDENT:  return is_digit(c) || is_alpha(c) || (c == ctt_pkg::CH_USCORE);
      default:              return 1'b0;
    endcase
  endfunction

  function automatic ctt_pkg::lex_work_t emit(ctt_pkg::lex_work_t w, ctt_pkg::kind_t k,
                                              logic [7:0] ch, logic v, logic l);
    ctt_pkg::result_t r;
    r.kind       = k;
    r.char_value = ch;
    r.char_valid = v;
    r.token_last = l;
    w.b.res[w.b.cnt] = r;
    w.b.cnt = w.b.cnt + 2'd1;
    return w;
  endfunction

  // Appends a character to the open token and releases the one held back.
  function automatic ctt_pkg::lex_work_t push_char(ctt_pkg::lex_work_t w, logic [7:0] c);
    if (w.r.held_valid) begin
      w = emit(w, mode_kind(w.r.mode), w.r.held_char, 1'b1, 1'b0);
    end
    w.r.held_char  = c;
    w.r.held_valid = 1'b1;
    return w;
  endfunction

  function automatic ctt_pkg::lex_work_t close_token(ctt_pkg::lex_work_t w);
    if (w.r.held_valid) begin
      w = emit(w, mode_kind(w.r.mode), w.r.held_char, 1'b1, 1'b1);
    end else if (w.r.mode == ctt_pkg::MODE_STRING) begin
      w = emit(w, ctt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1);
    end
    w.r.mode       = ctt_pkg::MODE_IDLE;
    w.r.held_char  = 8'h00;
    w.r.held_valid = 1'b0;
    w.r.escape     = 1'b0;
    return w;
  endfunction

  function automatic ctt_pkg::lex_work_t start_token(ctt_pkg::lex_work_t w, logic [7:0] c);
    case (c)
      ctt_pkg::CH_DOT:   w = emit(w, ctt_pkg::KIND_DOT, c, 1'b1, 1'b1);
      ctt_pkg::CH_EQ:    w = emit(w, ctt_pkg::KIND_EQ, c, 1'b1, 1'b1);
      ctt_pkg::CH_SEMI:  w = emit(w, ctt_pkg::KIND_SEMI, c, 1'b1, 1'b1);
      ctt_pkg::CH_OPEN:  w = emit(w, ctt_pkg::KIND_OPEN, c, 1'b1, 1'b1);
      ctt_pkg::CH_CLOSE: w = emit(w, ctt_pkg::KIND_CLOSE, c, 1'b1, 1'b1);
      ctt_pkg::CH_NL:    w = emit(w, ctt_pkg::KIND_NL, c, 1'b1, 1'b1);
      ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE: begin
        w.r.mode         = ctt_pkg::MODE_STRING;
        w.r.quote_single = (c == ctt_pkg::CH_SQUOTE);
        w.r.escape       = 1'b0;
        w.r.held_valid   = 1'b0;
        w.r.held_char    = 8'h00;
      end
      default: begin
        if (is_blank(c) || is_digit(c) || is_alpha(c) || (c == ctt_pkg::CH_USCORE)) begin
          if (is_blank(c)) begin
            w.r.mode = ctt_pkg::MODE_SPACE;
          end else if (is_digit(c)) begin
            w.r.mode = ctt_pkg::MODE_NUMBER;
          end else begin
            w.r.mode = ctt_pkg::MODE_IDENT;
          end
          w.r.held_char  = c;
          w.r.held_valid = 1'b1;
        end else begin
          w = emit(w, ctt_pkg::KIND_OTHER, c, 1'b1, 1'b1);
        end
      end
    endcase
    return w;
  endfunction

  function automatic ctt_pkg::lex_work_t step(ctt_pkg::lex_regs_t st, logic [7:0] c,
                                              logic eoi);
    ctt_pkg::lex_work_t w;
    logic [7:0]         q;
    w.r = st;
    w.b = '0;
    q   = st.quote_single ? ctt_pkg::CH_SQUOTE : ctt_pkg::CH_DQUOTE;
    if (eoi) begin
      // A pending backslash at end of input is kept as a literal backslash.
      if ((w.r.mode == ctt_pkg::MODE_STRING) && w.r.escape) begin
        w.r.escape = 1'b0;
        w = push_char(w, ctt_pkg::CH_BSLASH);
      end
      if (w.r.mode != ctt_pkg::MODE_IDLE) begin
        w = close_token(w);
      end
      w = emit(w, ctt_pkg::KIND_END, 8'h00, 1'b0, 1'b1);
      w.r = '0;
    end else if (w.r.mode == ctt_pkg::MODE_STRING) begin
      if (w.r.escape && (c == q)) begin
        w.r.escape = 1'b0;
        w = push_char(w, q);
      end else begin
        if (w.r.escape) begin
          w.r.escape = 1'b0;
          w = push_char(w, ctt_pkg::CH_BSLASH);
        end
        if (c == q) begin
          w = close_token(w);
        end else if (c == ctt_pkg::CH_BSLASH) begin
          w.r.escape = 1'b1;
        end else begin
          w = push_char(w, c);
        end
      end
    end else if ((w.r.mode != ctt_pkg::MODE_IDLE) && continues(w.r.mode, c)) begin
      w = push_char(w, c);
    end else begin
      if (w.r.mode != ctt_pkg::MODE_IDLE) begin
        w = close_token(w);
      end
      w = start_token(w, c);
    end
    return w;
  endfunction

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    work = step(regs, s_tdata, s_tlast);
  end

  assign push      = accept && (work.b.cnt != 2'd0);
  assign push_data = work.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (accept) begin
      regs <= work.r;
    end
  end

endmodule

FILE: rtl/ctt_queue.sv
`timescale 1ns / 1ps

module ctt_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ctt_pkg::bundle_t push_data,
  input  logic             pop,
  output ctt_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ctt_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == CW'(0));
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/ctt_back.sv
`timescale 1ns / 1ps

module ctt_back (
  input  logic             clk,
  input  logic             rst,
  input  ctt_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic [5:0]       m_tuser
);

  logic [1:0]       idx;
  logic             load;
  logic             final_res;
  ctt_pkg::result_t cur;

  assign cur       = head.res[idx];
  assign final_res = (idx == head.cnt - 2'd1);
  assign load      = !empty && (!m_tvalid || m_tready);
  assign pop       = load && final_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= final_res ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur.char_value;
      m_tlast <= cur.token_last;
      m_tuser <= {final_res, cur.char_valid, cur.kind};
    end
  end

endmodule

FILE: rtl/config_text_tokenizer.sv
`timescale 1ns / 1ps

// Streaming tokenizer for configuration text.
// Input channel s_*: one request per character; s_tdata carries the byte and
// s_tlast marks end of input, in which case s_tdata is ignored.
// Output channel m_*: one request per token character. m_tdata is the
// character, m_tlast marks the final character of a token, and m_tuser gives
// the token kind, whether the character is present, and the last result
// produced by one input request.
// A request yields zero to three results. With the queue empty, the results of
// an accepted request are written into the bundle queue at the accepting edge,
// and the first is then registered onto m_*. The lexer sustains one request per
// cycle while the queue is not full; the output side moves one result per cycle
// while m_tready is high, so runs of multi-result requests fill the bundle queue
// between the lexer and the output stage, and s_tready drops while it is full.
// Synchronous reset returns the lexer to idle and empties the queue and the
// output register. When the receiver holds m_tready low, the current result
// stays on m_*, and input is still taken until the queue fills.
module config_text_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_value
  output logic       m_tlast,
  output logic [5:0] m_tuser    // [3:0] token_kind, [4] char_valid, [5] run_last
);

  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  ctt_pkg::bundle_t push_data;
  ctt_pkg::bundle_t head;

  ctt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ctt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ctt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: rtl/ctt_checker.sv
`timescale 1ns / 1ps

module ctt_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [5:0] m_tuser
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
    $stable(m_tuser))
    else $error("stalled output result changed");

  // The end token closes both the token and the run and carries no character.
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[3:0] == ctt_pkg::KIND_END) |->
    m_tlast && m_tuser[5] && !m_tuser[4] && (m_tdata == 8'h00))
    else $error("malformed end token");

  // Results without a character only occur as the final result of a token.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[4] |-> m_tlast && (m_tdata == 8'h00))
    else $error("empty result that does not close a token");

  // Reset leaves no result pending on the output.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    ctt_pkg::kind_t kind;
    logic [7:0]     ch;
    logic           ch_ok;
    logic           tok_end;
    logic           item_end;
  } tok_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [5:0] m_tuser;

  // Lexer state as the block should hold it.
  ctt_pkg::mode_t lx_mode;
  logic [7:0]     lx_held;
  logic           lx_held_ok;
  logic           lx_single;
  logic           lx_escape;

  tok_char_t expected_chars[$];
  int new_chars;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int chars_checked = 0;
  int ends_sent = 0;

  config_text_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic reset_lexer();
    lx_mode = ctt_pkg::MODE_IDLE;
    lx_held = 8'h00;
    lx_held_ok = 1'b0;
    lx_single = 1'b0;
    lx_escape = 1'b0;
  endtask

  task automatic put_char(ctt_pkg::kind_t k, logic [7:0] c, logic ok, logic e);
    tok_char_t t;
    if (new_chars < ctt_pkg::MAX_RESULTS) begin
      t.kind = k;
      t.ch = c;
      t.ch_ok = ok;
      t.tok_end = e;
      t.item_end = 1'b0;
      expected_chars.push_back(t);
      new_chars++;
    end
  endtask

  function automatic ctt_pkg::kind_t open_kind();
    case (lx_mode)
      ctt_pkg::MODE_SPACE:  return ctt_pkg::KIND_SPACE;
      ctt_pkg::MODE_STRING: return ctt_pkg::KIND_STRING;
      ctt_pkg::MODE_NUMBER: return ctt_pkg::KIND_NUMBER;
      default:              return ctt_pkg::KIND_IDENT;
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Whitespace other than newline.
  function automatic bit is_blank(logic [7:0] c);
    return c == ctt_pkg::CH_SPACE ||
           (c >= ctt_pkg::CH_TAB && c <= ctt_pkg::CH_CR && c != ctt_pkg::CH_NL);
  endfunction

  // The last character of an open token is held until the next one arrives.
  task automatic append_char(logic [7:0] c);
    if (lx_held_ok) put_char(open_kind(), lx_held, 1'b1, 1'b0);
    lx_held = c;
    lx_held_ok = 1'b1;
  endtask

  task automatic close_open();
    if (lx_held_ok) put_char(open_kind(), lx_held, 1'b1, 1'b1);
    else if (lx_mode == ctt_pkg::MODE_STRING)
      put_char(ctt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1);
    lx_mode = ctt_pkg::MODE_IDLE;
    lx_held = 8'h00;
    lx_held_ok = 1'b0;
    lx_escape = 1'b0;
  endtask

  task automatic string_char(logic [7:0] c);
    logic [7:0] q;
    q = lx_single ? ctt_pkg::CH_SQUOTE : ctt_pkg::CH_DQUOTE;
    if (lx_escape) begin
      lx_escape = 1'b0;
      if (c == q) begin
        append_char(q);
        return;
      end
      append_char(ctt_pkg::CH_BSLASH);
    end
    if (c == q) close_open();
    else if (c == ctt_pkg::CH_BSLASH) lx_escape = 1'b1;
    else append_char(c);
  endtask

  function automatic bit extends_token(logic [7:0] c);
    case (lx_mode)
      ctt_pkg::MODE_SPACE:  return is_blank(c);
      ctt_pkg::MODE_NUMBER: return is_digit(c) || is_letter(c) || c == ctt_pkg::CH_DOT;
      ctt_pkg::MODE_IDENT:  return is_digit(c) || is_letter(c) || c == ctt_pkg::CH_USCORE;
      default:              return 1'b0;
    endcase
  endfunction

  task automatic begin_token(logic [7:0] c);
    case (c)
      ctt_pkg::CH_DOT:   put_char(ctt_pkg::KIND_DOT, c, 1'b1, 1'b1);
      ctt_pkg::CH_EQ:    put_char(ctt_pkg::KIND_EQ, c, 1'b1, 1'b1);
      ctt_pkg::CH_SEMI:  put_char(ctt_pkg::KIND_SEMI, c, 1'b1, 1'b1);
      ctt_pkg::CH_OPEN:  put_char(ctt_pkg::KIND_OPEN, c, 1'b1, 1'b1);
      ctt_pkg::CH_CLOSE: put_char(ctt_pkg::KIND_CLOSE, c, 1'b1, 1'b1);
      ctt_pkg::CH_NL:    put_char(ctt_pkg::KIND_NL, c, 1'b1, 1'b1);
      ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE: begin
        lx_mode = ctt_pkg::MODE_STRING;
        lx_single = (c == ctt_pkg::CH_SQUOTE);
        lx_escape = 1'b0;
        lx_held_ok = 1'b0;
        lx_held = 8'h00;
      end
      default: begin
        if (is_blank(c) || is_digit(c) || is_letter(c) || c == ctt_pkg::CH_USCORE) begin
          if (is_blank(c)) lx_mode = ctt_pkg::MODE_SPACE;
          else if (is_digit(c)) lx_mode = ctt_pkg::MODE_NUMBER;
          else lx_mode = ctt_pkg::MODE_IDENT;
          lx_held = c;
          lx_held_ok = 1'b1;
        end else begin
          put_char(ctt_pkg::KIND_OTHER, c, 1'b1, 1'b1);
        end
      end
    endcase
  endtask

  task automatic lex_request(logic [7:0] c, logic eoi);
    new_chars = 0;
    if (eoi) begin
      if (lx_mode == ctt_pkg::MODE_STRING && lx_escape) begin
        lx_escape = 1'b0;
        append_char(ctt_pkg::CH_BSLASH);
      end
      if (lx_mode != ctt_pkg::MODE_IDLE) close_open();
      put_char(ctt_pkg::KIND_END, 8'h00, 1'b0, 1'b1);
      reset_lexer();
    end else if (lx_mode == ctt_pkg::MODE_STRING) begin
      string_char(c);
    end else if (lx_mode != ctt_pkg::MODE_IDLE && extends_token(c)) begin
      append_char(c);
    end else begin
      if (lx_mode != ctt_pkg::MODE_IDLE) close_open();
      begin_token(c);
    end
    if (new_chars > 0) expected_chars[expected_chars.size() - 1].item_end = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    tok_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("unexpected result, char", m_tdata, 0);
    end else begin
      want = expected_chars.pop_front();
      chars_checked++;
      if (m_tuser[3:0] != want.kind) report_mismatch("token kind", m_tuser[3:0], want.kind);
      if (m_tdata != want.ch) report_mismatch("char value", m_tdata, want.ch);
      if (m_tuser[4] != want.ch_ok) report_mismatch("char valid", m_tuser[4], want.ch_ok);
      if (m_tlast != want.tok_end) report_mismatch("token last", m_tlast, want.tok_end);
      if (m_tuser[5] != want.item_end) report_mismatch("run last", m_tuser[5], want.item_end);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(logic [7:0] c, logic eoi);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lex_request(c, eoi);
    items_sent++;
    if (eoi) ends_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // The byte that travels with an end marker must be ignored.
  task automatic send_end();
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(4))
      0: return ctt_pkg::CH_TAB;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return ctt_pkg::CH_CR;
      default: return ctt_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(3))
      0: return 8'("0" + $urandom_range(9));
      1: return ctt_pkg::CH_USCORE;
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] rand_any();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(5))
          0: return ctt_pkg::CH_DOT;
          1: return ctt_pkg::CH_EQ;
          2: return ctt_pkg::CH_SEMI;
          3: return ctt_pkg::CH_OPEN;
          4: return ctt_pkg::CH_CLOSE;
          default: return ctt_pkg::CH_NL;
        endcase
      end
      1: return rand_blank();
      2: return rand_word_char();
      3: return $urandom_range(1) ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_BSLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_word();
    int n;
    n = $urandom_range(4);
    send_char($urandom_range(4) == 0 ? ctt_pkg::CH_USCORE : rand_letter(), 1'b0);
    repeat (n) send_char(rand_word_char(), 1'b0);
  endtask

  task automatic send_string_value();
    logic [7:0] q;
    int n;
    q = $urandom_range(1) ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_SQUOTE;
    n = $urandom_range(6);
    send_char(q, 1'b0);
    repeat (n) begin
      case ($urandom_range(6))
        0: send_char(ctt_pkg::CH_BSLASH, 1'b0);
        1: begin
          send_char(ctt_pkg::CH_BSLASH, 1'b0);
          send_char(q, 1'b0);
        end
        2: send_char(q == ctt_pkg::CH_DQUOTE ? ctt_pkg::CH_SQUOTE : ctt_pkg::CH_DQUOTE, 1'b0);
        3: send_char(rand_blank(), 1'b0);
        4: send_char(8'($urandom_range(255)), 1'b0);
        default: send_char(rand_letter(), 1'b0);
      endcase
    end
    // Now and then the string is left open across the line.
    if ($urandom_range(9) != 0) send_char(q, 1'b0);
  endtask

  // One line of configuration text: a section header or a key assignment.
  task automatic send_line();
    int n;
    if ($urandom_range(4) == 0) begin
      send_char(ctt_pkg::CH_OPEN, 1'b0);
      send_word();
      send_char(ctt_pkg::CH_CLOSE, 1'b0);
    end else begin
      send_word();
      if ($urandom_range(1)) send_char(rand_blank(), 1'b0);
      send_char(ctt_pkg::CH_EQ, 1'b0);
      if ($urandom_range(1)) send_char(ctt_pkg::CH_SPACE, 1'b0);
      case ($urandom_range(2))
        0: begin
          n = $urandom_range(4);
          send_char(8'("0" + $urandom_range(9)), 1'b0);
          repeat (n)
            send_char($urandom_range(3) == 0 ? ctt_pkg::CH_DOT : rand_word_char(), 1'b0);
        end
        1: send_string_value();
        default: begin
          send_word();
          send_char(ctt_pkg::CH_DOT, 1'b0);
          send_word();
        end
      endcase
      if ($urandom_range(1)) send_char(ctt_pkg::CH_SEMI, 1'b0);
    end
    send_char(ctt_pkg::CH_NL, 1'b0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_punctuation();
    send_text(".=;[]\n");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
  endtask

  // Escapes of both quote styles, an empty string, and end of input
  // arriving inside a string with a backslash pending.
  task automatic test_strings();
    send_text("\"\\x\"");
    send_text("''");
    send_text("'\\\\'\\");
    send_end();
  endtask

  // Identifier, space and number runs, a number open at end of input, and
  // an empty string never closed.
  task automatic test_open_runs();
    send_text("_9 1a.");
    send_end();
    send_char(ctt_pkg::CH_DQUOTE, 1'b0);
    send_end();
  endtask

  task automatic test_random_text(int idle_pct, int stall, int count);
    int start;
    int r;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 70) send_line();
      else if (r < 96) send_char(rand_any(), 1'b0);
      else send_end();
    end
  endtask

  initial begin
    int waited;
    reset_lexer();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_punctuation();
    test_strings();
    test_open_runs();
    test_random_text(0, 0, 56);
    test_random_text(75, 0, 56);
    test_random_text(0, 75, 56);
    test_random_text(27, 27, 56);
    s_tvalid <= 1'b0;

    waited = 0;
    while (expected_chars.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("results never produced, count", expected_chars.size(), 0);

    $display("Sent %0d requests (%0d end markers) under four flow-control mixes.",
             items_sent, ends_sent);
    $display("Checked %0d token characters; %0d mismatches.", chars_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ctt_pkg.sv
rtl/ctt_front.sv
rtl/ctt_queue.sv
rtl/ctt_back.sv
rtl/config_text_tokenizer.sv
rtl/ctt_checker.sv
verif/tb_top.sv
